// ===== rtl/core/ehx_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and the result record type of the Ethernet/IP/L4 header extractor.
// No dependencies.

package ehx_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  L4_PROTO_TCP   = 8'd6;
    localparam logic [7:0]  L4_PROTO_UDP   = 8'd17;

    localparam int DATA_W = 8;
    localparam int POS_W  = 16;

    // Minimum frame lengths for each header to be wholly present.
    localparam logic [POS_W-1:0] ETH_MIN_LEN      = 16'd14;
    localparam logic [POS_W-1:0] IPV4_MIN_LEN     = 16'd34;
    localparam logic [POS_W-1:0] IPV6_MIN_LEN     = 16'd54;
    localparam logic [POS_W-1:0] IPV4_TCP_MIN_LEN = 16'd54;
    localparam logic [POS_W-1:0] IPV4_UDP_MIN_LEN = 16'd42;
    localparam logic [POS_W-1:0] IPV6_TCP_MIN_LEN = 16'd74;
    localparam logic [POS_W-1:0] IPV6_UDP_MIN_LEN = 16'd62;
    localparam logic [POS_W-1:0] POS_MAX          = 16'hFFFF;

    // Packed so that dest_mac sits in the lowest bits and frame_length in the highest.
    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [63:0] dest_addr_low;
        logic [63:0] dest_addr_high;
        logic [63:0] source_addr_low;
        logic [63:0] source_addr_high;
        logic [7:0]  ip_protocol;
        logic [15:0] ether_type;
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
    } ehx_record_t;

    localparam int RECORD_W = $bits(ehx_record_t);

endpackage

// ===== rtl/core/eth_ip_l4_header_extractor_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Ethernet/IPv4/IPv6/TCP/UDP header extractor.
// Depends on ehx_pkg and ehx_parser.
//
// Usage:
//   An Ethernet frame arrives on the slave channel one byte per item, in wire
//   order, with s_tlast high on the final byte. For every frame of at least
//   14 bytes one record item leaves on the master channel when the final byte
//   has been parsed; shorter frames produce no item. The record carries both
//   MAC addresses, the ethertype, the IP protocol, source and destination
//   addresses, TCP/UDP ports and the frame length (saturating at 65535).
//   Fields whose header is not wholly present in the frame read zero.
//
//   The final byte is captured into the input register; its record is
//   assembled combinationally from that register and the stored captures and
//   loaded into the record register, which drives m_tvalid and m_tdata.
//   Throughput is one byte per cycle while no final byte waits for the record
//   slot, set by the single registered pass of the capture logic between the
//   input register and the record register.
//
//   Reset (aresetn low, synchronous) empties both registers and restarts the
//   byte count, so the next byte is taken as the first of a new frame.
//   When the receiver stalls, the record holds in the output register; bytes
//   that do not end a frame keep flowing, and a final byte that yields a record
//   waits in the input register until the record slot frees up, holding s_tready low.

module eth_ip_l4_header_extractor_unit
    import ehx_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,   // last_byte

    output logic                m_tvalid,
    input  logic                m_tready,
    // From bit 0 up: dest_mac[48], source_mac[48], ether_type[16], ip_protocol[8],
    // source_addr_high[64], source_addr_low[64], dest_addr_high[64],
    // dest_addr_low[64], source_port[16], dest_port[16], frame_length[16].
    output logic [RECORD_W-1:0] m_tdata
);

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic              out_valid_reg;
    ehx_record_t       rec_reg;

    ehx_record_t       rec;
    logic              rec_valid;
    logic              out_free;
    logic              step;
    logic              s_accept;

    // A byte leaves the input register unless it ends a frame that yields a
    // record and the record slot is still occupied.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!rec_valid || out_free);
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    ehx_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .rec       (rec),
        .rec_valid (rec_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end

            if (step && rec_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step && rec_valid) begin
            rec_reg <= rec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rec_reg;

endmodule

// ===== rtl/core/ehx_parser.sv =====
`timescale 1ns / 1ps
// Byte position counter, header capture registers and record assembly.
// Depends on ehx_pkg.

module ehx_parser
    import ehx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              last_byte,
    output ehx_record_t       rec,
    output logic              rec_valid
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [47:0]      dmac_reg, dmac_next;
    logic [47:0]      smac_reg, smac_next;
    logic [15:0]      type_reg, type_next;
    logic [7:0]       proto_reg, proto_next;
    logic [63:0]      addr0_reg, addr0_next;
    logic [63:0]      addr1_reg, addr1_next;
    logic [63:0]      addr2_reg, addr2_next;
    logic [63:0]      addr3_reg, addr3_next;
    logic [15:0]      port0_reg, port0_next;
    logic [15:0]      port1_reg, port1_next;

    logic [POS_W-1:0] len;
    logic             first;
    logic             is_v4;
    logic             is_v6;
    logic             ip_ok;
    logic             l4_ok;

    // Capture the current byte on top of the stored fields (cleared at a frame start).
    always_comb begin
        first      = (pos_reg == '0);
        dmac_next  = first ? '0 : dmac_reg;
        smac_next  = first ? '0 : smac_reg;
        type_next  = first ? '0 : type_reg;
        proto_next = first ? '0 : proto_reg;
        addr0_next = first ? '0 : addr0_reg;
        addr1_next = first ? '0 : addr1_reg;
        addr2_next = first ? '0 : addr2_reg;
        addr3_next = first ? '0 : addr3_reg;
        port0_next = first ? '0 : port0_reg;
        port1_next = first ? '0 : port1_reg;

        if (pos_reg < 16'd6) begin
            dmac_next = {dmac_next[39:0], data_byte};
        end else if (pos_reg < 16'd12) begin
            smac_next = {smac_next[39:0], data_byte};
        end else if (pos_reg < 16'd14) begin
            type_next = {type_next[7:0], data_byte};
        end else if (type_reg == ETHERTYPE_IPV4) begin
            if (pos_reg == 16'd23) begin
                proto_next = data_byte;
            end else if (pos_reg inside {[16'd26:16'd29]}) begin
                addr1_next = {addr1_next[55:0], data_byte};
            end else if (pos_reg inside {[16'd30:16'd33]}) begin
                addr3_next = {addr3_next[55:0], data_byte};
            end else if (pos_reg inside {[16'd34:16'd35]}) begin
                port0_next = {port0_next[7:0], data_byte};
            end else if (pos_reg inside {[16'd36:16'd37]}) begin
                port1_next = {port1_next[7:0], data_byte};
            end
        end else if (type_reg == ETHERTYPE_IPV6) begin
            if (pos_reg == 16'd20) begin
                proto_next = data_byte;
            end else if (pos_reg inside {[16'd22:16'd29]}) begin
                addr0_next = {addr0_next[55:0], data_byte};
            end else if (pos_reg inside {[16'd30:16'd37]}) begin
                addr1_next = {addr1_next[55:0], data_byte};
            end else if (pos_reg inside {[16'd38:16'd45]}) begin
                addr2_next = {addr2_next[55:0], data_byte};
            end else if (pos_reg inside {[16'd46:16'd53]}) begin
                addr3_next = {addr3_next[55:0], data_byte};
            end else if (pos_reg inside {[16'd54:16'd55]}) begin
                port0_next = {port0_next[7:0], data_byte};
            end else if (pos_reg inside {[16'd56:16'd57]}) begin
                port1_next = {port1_next[7:0], data_byte};
            end
        end

        len      = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 16'd1;
        pos_next = last_byte ? '0 : len;
    end

    // Record assembly from the updated captures.
    always_comb begin
        is_v4 = (type_next == ETHERTYPE_IPV4) && (len >= IPV4_MIN_LEN);
        is_v6 = (type_next == ETHERTYPE_IPV6) && (len >= IPV6_MIN_LEN);
        ip_ok = is_v4 || is_v6;
        l4_ok = 1'b0;
        if (is_v4) begin
            l4_ok = ((proto_next == L4_PROTO_TCP) && (len >= IPV4_TCP_MIN_LEN)) ||
                    ((proto_next == L4_PROTO_UDP) && (len >= IPV4_UDP_MIN_LEN));
        end else if (is_v6) begin
            l4_ok = ((proto_next == L4_PROTO_TCP) && (len >= IPV6_TCP_MIN_LEN)) ||
                    ((proto_next == L4_PROTO_UDP) && (len >= IPV6_UDP_MIN_LEN));
        end

        rec_valid            = last_byte && (len >= ETH_MIN_LEN);
        rec                  = '0;
        rec.dest_mac         = dmac_next;
        rec.source_mac       = smac_next;
        rec.ether_type       = type_next;
        rec.frame_length     = len;
        rec.ip_protocol      = ip_ok ? proto_next : '0;
        rec.source_addr_high = is_v6 ? addr0_next : '0;
        rec.dest_addr_high   = is_v6 ? addr2_next : '0;
        if (is_v6) begin
            rec.source_addr_low = addr1_next;
            rec.dest_addr_low   = addr3_next;
        end else if (is_v4) begin
            rec.source_addr_low = {32'd0, addr1_next[31:0]};
            rec.dest_addr_low   = {32'd0, addr3_next[31:0]};
        end
        rec.source_port = l4_ok ? port0_next : '0;
        rec.dest_port   = l4_ok ? port1_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (step) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            dmac_reg  <= dmac_next;
            smac_reg  <= smac_next;
            type_reg  <= type_next;
            proto_reg <= proto_next;
            addr0_reg <= addr0_next;
            addr1_reg <= addr1_next;
            addr2_reg <= addr2_next;
            addr3_reg <= addr3_next;
            port0_reg <= port0_next;
            port1_reg <= port1_next;
        end
    end

endmodule
